// ===== rtl/core/gpg_pkg.sv =====
package gpg_pkg;

	localparam int          NUM_STREAMS_DEF = 2;
	localparam logic [47:0] SEED_RESET      = 48'h1234ABCD330E;
	localparam logic [34:0] LCG_MUL         = 35'h5DEECE66D;
	localparam logic [47:0] LCG_ADD         = 48'hB;
	localparam int          LCG_CHUNK       = 5;
	localparam int          LCG_STEPS       = 7;
	localparam logic [31:0] TWO_LN2_Q30     = 32'd1488522236;
	localparam int          LOG_BITS        = 26;

	typedef struct packed {
		logic               stream;
		logic signed [31:0] mean;
		logic [30:0]        spread;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               clipped;
	} out_t;

endpackage

// ===== rtl/core/gpg_lcg.sv =====
module gpg_lcg
	import gpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [47:0] load_val,
	input  logic        start,
	output logic        done,
	output logic [31:0] u
);

	logic [47:0] s_q;
	logic [47:0] acc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [4:0]  chunk;
	logic [47:0] acc_next;

	always_comb begin
		chunk    = 5'(LCG_MUL >> (LCG_CHUNK * int'(cnt_q)));
		acc_next = acc_q + 48'((s_q * {43'd0, chunk}) << (LCG_CHUNK * int'(cnt_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q    <= SEED_RESET;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				s_q    <= load_val;
				busy_q <= 1'b0;
			end else if (start) begin
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (int'(cnt_q) == LCG_STEPS - 1) begin
					s_q    <= acc_next + LCG_ADD;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign u    = {~s_q[47], s_q[46:16]};

endmodule

// ===== rtl/core/gpg_isqrt.sv =====
module gpg_isqrt
	import gpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] op_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] rn;
	logic [34:0] trial;

	always_comb begin
		rn    = {rem_q, op_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q   <= operand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				op_q <= {op_q[61:0], 2'b00};
				if (rn >= trial) begin
					rem_q  <= 33'(rn - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rn[32:0];
					root_q <= {root_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/core/gpg_div.sv =====
module gpg_div
	import gpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] num,
	input  logic [30:0] den,
	output logic        done,
	output logic [31:0] quot
);

	logic [60:0] dq_q;
	logic [30:0] rem_q;
	logic [30:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] rn;
	logic        qbit;

	always_comb begin
		rn   = {rem_q, dq_q[60]};
		qbit = rn >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q   <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dq_q   <= {num, 30'd0};
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? 31'(rn - {1'b0, den_q}) : rn[30:0];
				dq_q  <= {dq_q[59:0], qbit};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd60) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = dq_q[31:0];

endmodule

// ===== rtl/core/gaussian_polar_generator_unit.sv =====
// Gaussian sample generator, Marsaglia polar method, Q8.24 in and out. A request
// on a stream that holds a cached deviate goes through ST_SMUL and ST_OUT to the
// output register. Otherwise the block draws pairs from a 48-bit congruential
// generator (one pair per attempt, a rejected attempt draws a new pair), then
// normalizes, runs 26 squaring rounds for the logarithm on one shared 32x32
// multiplier, two 32-step square roots and two 61-step divisions; a fresh pair
// fills the stream's cache. The block takes no new request until the result is
// in the output register, and holds there while the previous result is stalled.
// Writing the seed reloads the generator and empties every cache.
module gaussian_polar_generator_unit
	import gpg_pkg::*;
#(
	parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_wr_en,
	input  logic [47:0] cfg_wr_data
);

	localparam int SIDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DRAW1, ST_DRAW2, ST_SQ1, ST_SQ2, ST_SUMW, ST_NORM, ST_LOG,
		ST_LNMUL, ST_RSQ, ST_DSQ, ST_DIV1, ST_MUL1, ST_DIV2, ST_MUL2, ST_SMUL, ST_OUT
	} state_t;

	state_t              state_q;
	logic [SIDX_W-1:0]   sidx_q;
	logic [SIDX_W-1:0]   sidx;
	logic signed [31:0]  mean_q;
	logic [30:0]         spread_q;
	logic signed [31:0]  cache_q [NUM_STREAMS];
	logic [NUM_STREAMS-1:0] cache_vld_q;
	logic                n1_q, n2_q;
	logic [31:0]         a1_q, a2_q;
	logic [62:0]         sq_q;
	logic [63:0]         w_q;
	logic [4:0]          k_q;
	logic [5:0]          e_q;
	logic [31:0]         m_q;
	logic [25:0]         f_q;
	logic [4:0]          cnt_q;
	logic [33:0]         l_q;
	logic [31:0]         r_q;
	logic [30:0]         den_q;
	logic [31:0]         t_q;
	logic signed [31:0]  dev_q;
	logic [36:0]         p_q;
	logic                neg_q;
	logic                lcg_go_q, sqrt_go_q, div_go_q;
	logic                out_valid_q;
	out_t                out_q;

	logic [31:0]         u;
	logic                lcg_done, sqrt_done, div_done;
	logic [31:0]         root, quot;
	logic [63:0]         sqrt_op;
	logic [30:0]         div_num;
	logic [31:0]         mul_a, mul_b, prod_hi;
	logic [63:0]         prod;
	logic [31:0]         n_c, dmag, dev_mag;
	logic [31:0]         u_abs;
	logic signed [38:0]  sum_c;
	logic                clip_c;
	logic signed [31:0]  sat_c;

	gpg_lcg u_lcg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cfg_wr_en),
		.load_val (cfg_wr_data),
		.start    (lcg_go_q),
		.done     (lcg_done),
		.u        (u)
	);

	gpg_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_go_q),
		.operand (sqrt_op),
		.done    (sqrt_done),
		.root    (root)
	);

	gpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		if (int'(in_data.stream) >= NUM_STREAMS) begin
			sidx = SIDX_W'(NUM_STREAMS - 1);
		end else begin
			sidx = SIDX_W'(in_data.stream);
		end
		u_abs   = u[31] ? 32'(-u) : u;
		n_c     = {6'(6'd62 - e_q), 26'd0} - {6'd0, f_q};
		dev_mag = dev_q[31] ? 32'(-dev_q) : 32'(dev_q);
		sqrt_op = (state_q == ST_RSQ) ? {4'd0, l_q, 26'd0} : {2'b00, w_q[61:0]};
		div_num = (state_q == ST_DIV2) ? a2_q[30:0] : a1_q[30:0];
		unique case (state_q)
			ST_SQ1:   begin mul_a = a1_q;              mul_b = a1_q;        end
			ST_SQ2:   begin mul_a = a2_q;              mul_b = a2_q;        end
			ST_LOG:   begin mul_a = m_q;               mul_b = m_q;         end
			ST_LNMUL: begin mul_a = n_c;               mul_b = TWO_LN2_Q30; end
			ST_MUL1,
			ST_MUL2:  begin mul_a = t_q;               mul_b = r_q;         end
			ST_SMUL:  begin mul_a = {1'b0, spread_q};  mul_b = dev_mag;     end
			default:  begin mul_a = '0;                mul_b = '0;          end
		endcase
		prod    = mul_a * mul_b;
		prod_hi = prod[63:32];
		dmag    = prod[61:30];
		sum_c   = 39'(mean_q) + (neg_q ? -$signed({2'b00, p_q}) : $signed({2'b00, p_q}));
		clip_c  = (sum_c > 39'sd2147483647) || (sum_c < -39'sd2147483648);
		if (sum_c > 39'sd2147483647) begin
			sat_c = 32'sh7FFFFFFF;
		end else if (sum_c < -39'sd2147483648) begin
			sat_c = 32'sh80000000;
		end else begin
			sat_c = sum_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sidx_q      <= '0;
			mean_q      <= '0;
			spread_q    <= '0;
			for (int i = 0; i < NUM_STREAMS; i++) cache_q[i] <= '0;
			cache_vld_q <= '0;
			n1_q        <= 1'b0;
			n2_q        <= 1'b0;
			a1_q        <= '0;
			a2_q        <= '0;
			sq_q        <= '0;
			w_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			m_q         <= '0;
			f_q         <= '0;
			cnt_q       <= '0;
			l_q         <= '0;
			r_q         <= '0;
			den_q       <= '0;
			t_q         <= '0;
			dev_q       <= '0;
			p_q         <= '0;
			neg_q       <= 1'b0;
			lcg_go_q    <= 1'b0;
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			lcg_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sidx_q   <= sidx;
						mean_q   <= in_data.mean;
						spread_q <= in_data.spread;
						if (cache_vld_q[sidx]) begin
							dev_q              <= cache_q[sidx];
							cache_vld_q[sidx]  <= 1'b0;
							state_q            <= ST_SMUL;
						end else begin
							lcg_go_q <= 1'b1;
							state_q  <= ST_DRAW1;
						end
					end
				end
				ST_DRAW1: begin
					if (lcg_done) begin
						n1_q     <= u[31];
						a1_q     <= u_abs;
						lcg_go_q <= 1'b1;
						state_q  <= ST_DRAW2;
					end
				end
				ST_DRAW2: begin
					if (lcg_done) begin
						n2_q    <= u[31];
						a2_q    <= u_abs;
						state_q <= ST_SQ1;
					end
				end
				ST_SQ1: begin
					sq_q    <= prod[62:0];
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					w_q     <= {1'b0, sq_q} + prod;
					state_q <= ST_SUMW;
				end
				ST_SUMW: begin
					if (w_q == 64'd0 || w_q[63:62] != 2'b00) begin
						lcg_go_q <= 1'b1;
						state_q  <= ST_DRAW1;
					end else begin
						k_q     <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (w_q[61:60] == 2'b00) begin
						w_q  <= {w_q[61:0], 2'b00};
						a1_q <= {a1_q[30:0], 1'b0};
						a2_q <= {a2_q[30:0], 1'b0};
						k_q  <= k_q + 5'd1;
					end else begin
						e_q     <= (w_q[61] ? 6'd61 : 6'd60) - {k_q, 1'b0};
						m_q     <= w_q[61] ? w_q[61:30] : w_q[60:29];
						f_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					if (prod[63]) begin
						m_q <= prod_hi;
					end else begin
						m_q <= prod[62:31];
					end
					f_q   <= {f_q[24:0], prod[63]};
					cnt_q <= cnt_q + 5'd1;
					if (int'(cnt_q) == LOG_BITS - 1) begin
						state_q <= ST_LNMUL;
					end
				end
				ST_LNMUL: begin
					l_q       <= prod[63:30];
					sqrt_go_q <= 1'b1;
					state_q   <= ST_RSQ;
				end
				ST_RSQ: begin
					if (sqrt_done) begin
						r_q       <= root;
						sqrt_go_q <= 1'b1;
						state_q   <= ST_DSQ;
					end
				end
				ST_DSQ: begin
					if (sqrt_done) begin
						den_q    <= root[30:0];
						div_go_q <= 1'b1;
						state_q  <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						t_q     <= quot;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					dev_q    <= n1_q ? -$signed(dmag) : $signed(dmag);
					div_go_q <= 1'b1;
					state_q  <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done) begin
						t_q     <= quot;
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					cache_q[sidx_q]     <= n2_q ? -$signed(dmag) : $signed(dmag);
					cache_vld_q[sidx_q] <= 1'b1;
					state_q             <= ST_SMUL;
				end
				ST_SMUL: begin
					p_q     <= prod[62:26];
					neg_q   <= dev_q[31];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.sample  <= sat_c;
						out_q.clipped <= clip_c;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_wr_en) begin
				cache_vld_q <= '0;
				for (int i = 0; i < NUM_STREAMS; i++) cache_q[i] <= '0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cache_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL2 && !cfg_wr_en) |=> cache_vld_q[sidx_q])
		else $error("cache not filled after fresh pair");
	a_den_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 || state_q == ST_DIV2) |-> den_q[30])
		else $error("divisor below normalized range");
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1 || state_q == ST_MUL2) |-> (t_q <= 32'h40000001))
		else $error("quotient out of range");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOG) |-> (w_q[61:60] != 2'b00 && w_q[63:62] == 2'b00))
		else $error("pair not normalized");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> state_q == ST_OUT)
		else $error("result overwrote pending output");

endmodule

// ===== sim/gaussian_polar_generator_unit_test.sv =====
`timescale 1ns / 100ps

module gaussian_polar_generator_unit_test;
	import gpg_pkg::*;

	class sample_scoreboard;
		logic [47:0]        rng;
		logic signed [63:0] held_dev [2];
		bit                 held_ok [2];
		out_t               pending [$];
		int                 mismatches;

		function void reseed(logic [47:0] s);
			rng = s;
			for (int i = 0; i < 2; i++) begin
				held_dev[i] = 0;
				held_ok[i] = 0;
			end
		endfunction

		function longint draw();
			rng = (rng * 48'h5DEECE66D + 48'hB);
			return longint'({16'd0, rng[47:16]}) - 64'sd2147483648;
		endfunction

		function logic [63:0] root(logic [63:0] v);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function int msb(logic [63:0] v);
			int e;
			e = 0;
			while (e < 63 && (v >> (e + 1)) != 0) e++;
			return e;
		endfunction

		function logic [63:0] radius(logic [63:0] w);
			int          e;
			logic [63:0] m, f, n, l;
			e = msb(w);
			m = (e >= 31) ? (w >> (e - 31)) : (w << (31 - e));
			f = 0;
			for (int i = 0; i < LOG_BITS; i++) begin
				m = (m * m) >> 31;
				f = f << 1;
				if (m >= (64'd1 << 32)) begin
					f = f | 1;
					m = m >> 1;
				end
			end
			n = (64'(62 - e) << LOG_BITS) - f;
			l = (n * 64'(TWO_LN2_Q30)) >> 30;
			return root(l << 26);
		endfunction

		function longint deviate(longint u, logic [63:0] w, logic [63:0] r);
			int          e, k;
			logic [63:0] mag, den, t, d;
			e = msb(w);
			k = (e < 60) ? (61 - e) / 2 : 0;
			mag = (u < 0) ? -u : u;
			den = root(w << (2 * k));
			t = ((mag << k) << 30) / den;
			d = (t * r) >> 30;
			return (u < 0) ? -longint'(d) : longint'(d);
		endfunction

		function void note_request(in_t req);
			int          s;
			longint      dev, u1, u2, p, sum;
			logic [63:0] w, r, mag;
			out_t        res;
			s = req.stream;
			if (held_ok[s]) begin
				dev = held_dev[s];
				held_ok[s] = 0;
			end else begin
				do begin
					u1 = draw();
					u2 = draw();
					w = u1 * u1 + u2 * u2;
				end while (w == 0 || w >= (64'd1 << 62));
				r = radius(w);
				dev = deviate(u1, w, r);
				held_dev[s] = deviate(u2, w, r);
				held_ok[s] = 1;
			end
			mag = (dev < 0) ? -dev : dev;
			p = longint'((64'(req.spread) * mag) >> 26);
			if (dev < 0) p = -p;
			sum = longint'(req.mean) + p;
			res.clipped = 0;
			if (sum > 64'sd2147483647) begin
				sum = 64'sd2147483647;
				res.clipped = 1;
			end else if (sum < -64'sd2147483648) begin
				sum = -64'sd2147483648;
				res.clipped = 1;
			end
			res.sample = sum[31:0];
			pending.push_back(res);
		endfunction

		function void check_sample(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected sample %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.sample !== want.sample || got.clipped !== want.clipped) begin
				mismatches++;
				if (mismatches <= 10)
					$display("sample exp %h/%b got %h/%b", want.sample, want.clipped,
						got.sample, got.clipped);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	in_t         in_data;
	out_t        out_data;
	logic        cfg_wr_en;
	logic [47:0] cfg_wr_data;

	sample_scoreboard sb;
	int          send_idle, recv_idle, hold_cycles;
	longint      cycles;

	gaussian_polar_generator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_sample(out_data);
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic send(in_t req);
		in_data <= req;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(req);
		@(negedge clk);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			in_data <= in_t'({$urandom, $urandom});
			@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_seed(logic [47:0] s);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= s;
		@(negedge clk);
		cfg_wr_en <= 0;
		sb.reseed(s);
	endtask

	function automatic in_t random_req();
		in_t r;
		r.stream = 1'($urandom_range(1));
		case ($urandom_range(5))
			0: r.mean = 32'h7FFFFFFF - $urandom_range(255);
			1: r.mean = 32'h80000000 + $urandom_range(255);
			default: r.mean = $urandom;
		endcase
		case ($urandom_range(3))
			0: r.spread = 31'($urandom_range(32'h7FFFFFFF));
			1: r.spread = 31'h7FFFFFFF;
			default: r.spread = 31'($urandom_range(32'h03FFFFFF));
		endcase
		return r;
	endfunction

	initial begin
		in_t req;
		sb = new();
		sb.reseed(SEED_RESET);
		cycles = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int i = 0; i < 20; i++) begin
			req.stream = i[0];
			req.mean = (i % 4 == 0) ? 32'h7FFFFFFF : (i % 4 == 1) ? 32'h80000000 :
				(i % 4 == 2) ? 32'h0 : 32'hFFFFFFFF;
			req.spread = (i < 8) ? 31'h7FFFFFFF : (i < 12) ? 31'h0 : 31'h01000000;
			send(req);
		end
		write_seed(48'h0);
		for (int i = 0; i < 4; i++) begin
			req = random_req();
			send(req);
		end

		write_seed(48'hFFFFFFFFFFFF);
		send_idle = 18;
		recv_idle = 48;
		for (int i = 0; i < 640; i++) send(random_req());

		drain();
		hold_cycles <= 2000;
		for (int i = 0; i < 10; i++) send(random_req());

		write_seed(48'({$urandom, $urandom}));
		send_idle = 48;
		recv_idle = 18;
		for (int i = 0; i < 640; i++) send(random_req());

		write_seed(SEED_RESET);
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 640; i++) send(random_req());

		drain();
		repeat (400) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== gaussian_polar_generator_unit.f =====
rtl/core/gpg_pkg.sv
rtl/core/gpg_lcg.sv
rtl/core/gpg_isqrt.sv
rtl/core/gpg_div.sv
rtl/core/gaussian_polar_generator_unit.sv
sim/gaussian_polar_generator_unit_test.sv
